// ----- rtl/core/swcs_pkg.sv -----
package swcs_pkg;

  localparam int NUM_CH = 10;
  localparam int SAMPLE_W = 24;
  localparam int WINDOW_DEPTH_DEF = 80;
  localparam int SUM_W = 64;
  localparam int FILL_W = 7;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         query_column;
    logic signed [23:0] sample_ch0;
    logic signed [23:0] sample_ch1;
    logic signed [23:0] sample_ch2;
    logic signed [23:0] sample_ch3;
    logic signed [23:0] sample_ch4;
    logic signed [23:0] sample_ch5;
    logic signed [23:0] sample_ch6;
    logic signed [23:0] sample_ch7;
    logic signed [23:0] sample_ch8;
    logic signed [23:0] sample_ch9;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] window_mean;
    logic [22:0]        window_rms;
    logic signed [23:0] window_minimum;
    logic [23:0]        window_peak_magnitude;
    logic [25:0]        imbalance_mean;
    logic [6:0]         fill_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_SUB,
    ST_PUSH_ADD,
    ST_Q_RD,
    ST_Q_SCAN,
    ST_Q_DIV_IMB,
    ST_Q_DIV_MEAN,
    ST_Q_DIV_SQ,
    ST_Q_SQRT,
    ST_OUT
  } state_t;

  // Start request to the iterative arithmetic unit.
  typedef struct packed {
    logic            start;
    logic            is_sqrt;
    logic [SUM_W-1:0] operand;
    logic [SUM_W-1:0] divisor;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] result;
  } arith_rsp_t;

endpackage

// ----- rtl/core/swcs_arith.sv -----
// Shared unsigned divider (one quotient bit per cycle) and square root
// (one result bit per cycle).
module swcs_arith (
  input  logic                clk,
  input  logic                rst,
  input  swcs_pkg::arith_req_t req,
  output swcs_pkg::arith_rsp_t rsp
);

  localparam int W = swcs_pkg::SUM_W;

  logic             busy;
  logic             is_sqrt;
  logic [6:0]       cnt;
  logic [W-1:0]     num;
  logic [W-1:0]     den;
  logic [W:0]       rem;
  logic [W-1:0]     quo;
  logic [W+1:0]     srem;
  logic [W-1:0]     sres;
  logic             done;

  logic [W:0]       rem_sh;
  logic [W+1:0]     srem_sh;
  logic [W+1:0]     trial;

  always_comb begin
    rem_sh = {rem[W-1:0], num[W-1]};
    srem_sh = {srem[W-1:0], num[W-1:W-2]};
    trial = {sres, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        is_sqrt <= req.is_sqrt;
        num <= req.operand;
        den <= req.divisor;
        rem <= '0;
        quo <= '0;
        srem <= '0;
        sres <= '0;
        cnt <= req.is_sqrt ? 7'(W / 2) : 7'(W);
      end else if (busy) begin
        if (is_sqrt) begin
          num <= {num[W-3:0], 2'b00};
          if (srem_sh >= trial) begin
            srem <= srem_sh - trial;
            sres <= {sres[W-2:0], 1'b1};
          end else begin
            srem <= srem_sh;
            sres <= {sres[W-2:0], 1'b0};
          end
        end else begin
          num <= {num[W-2:0], 1'b0};
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[W-2:0], 1'b0};
          end
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.result = is_sqrt ? sres : quo;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start) else $error("arith restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !busy) else $error("done while busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 7'd0) else $error("counter underflow");

endmodule

// ----- rtl/core/sliding_window_channel_stats_core.sv -----
// Windowed statistics over ten signed Q11.12 channels.
// Input channel (in_valid/in_ready, in_item_t): opcode 0 pushes a
// ten-channel sample into a ring of WINDOW_DEPTH entries held in one
// synchronous memory; opcode 1 queries one channel.
// Output channel (out_valid/out_ready, out_item_t): one beat per query,
// none per push.
// A push first reads the oldest ring row. For each channel it then squares
// the old sample and subtracts it from the running sums (only once the
// window is full), then squares and adds the new sample in the same way;
// the new row is written back at the end of the add sweep.
// A query walks the ring memory for the min/peak (one row per cycle),
// then runs three divides and a square root in the shared arithmetic
// unit before the output register. A query on an empty window goes
// straight to the output register. One item is in work at a time;
// in_ready is high only when the engine is idle. The result sits in an
// output register until out_ready takes it, and the next item can be
// accepted meanwhile, unless it is a query on an empty window.
// Reset clears the fill count, write pointer and all running sums; the
// ring contents are left as they are, and a row is never used before being written.
module sliding_window_channel_stats_core #(
  parameter int WINDOW_DEPTH = swcs_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  swcs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output swcs_pkg::out_item_t out_item
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int NC = swcs_pkg::NUM_CH;
  localparam int SW = swcs_pkg::SAMPLE_W;
  localparam int W  = swcs_pkg::SUM_W;

  logic [NC*SW-1:0] ring_mem [WINDOW_DEPTH];
  logic [NC*SW-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic             wr_en;

  swcs_pkg::state_t state, state_next;
  logic [AW-1:0]    wr_ptr;
  logic [CW-1:0]    held;
  logic [CW-1:0]    scan_k;
  logic [3:0]       col;
  logic [NC*SW-1:0] new_row;
  logic signed [W-1:0] ch_sum [NC];
  logic signed [W-1:0] sq_sum [NC];
  logic signed [W-1:0] imb_sum;
  logic signed [SW-1:0] mn;
  logic [SW-1:0]    peak;
  logic             mean_neg;
  logic             imb_neg;
  logic signed [W-1:0] mean_q;
  logic [W-1:0]     imb_q;
  logic [W-1:0]     rms_q;
  logic             first;
  logic             phase_wait;
  logic [3:0]       ch_idx;
  logic signed [2*SW-1:0] sq_prod;

  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wr_ptr] <= new_row;
    if (rd_en) rd_data <= ring_mem[rd_addr];
  end

  swcs_pkg::arith_req_t req;
  swcs_pkg::arith_rsp_t rsp;

  swcs_arith u_arith (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  function automatic logic signed [SW-1:0] row_ch(logic [NC*SW-1:0] r, logic [3:0] c);
    return r[(NC-1-32'(c))*SW +: SW];
  endfunction

  function automatic logic [W-1:0] abs_imb(logic [NC*SW-1:0] r);
    logic signed [W-1:0] t;
    t = W'(row_ch(r, 4'd0)) + W'(row_ch(r, 4'd1)) + W'(row_ch(r, 4'd2))
        - W'(row_ch(r, 4'd6));
    return t[W-1] ? -t : t;
  endfunction

  function automatic logic [W-1:0] mag(logic signed [W-1:0] s);
    return s[W-1] ? W'(-s) : W'(s);
  endfunction

  logic signed [SW-1:0] cur_v;
  logic [SW-1:0] cur_a;
  always_comb begin
    cur_v = row_ch(rd_data, col);
    cur_a = cur_v[SW-1] ? SW'(-cur_v) : SW'(cur_v);
  end

  // Sample of channel ch_idx to square during the add/subtract sweep; the product is registered.
  logic signed [SW-1:0] sweep_v;
  always_comb begin
    sweep_v = (state == swcs_pkg::ST_PUSH_SUB) ? row_ch(rd_data, ch_idx)
                                               : row_ch(new_row, ch_idx);
  end

  always_ff @(posedge clk) sq_prod <= sweep_v * sweep_v;

  always_comb begin
    state_next = state;
    in_ready = (state == swcs_pkg::ST_IDLE);
    rd_en = 1'b0;
    rd_addr = wr_ptr;
    wr_en = 1'b0;
    req = '0;
    case (state)
      swcs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_item.opcode == swcs_pkg::OP_PUSH) begin
            state_next = swcs_pkg::ST_PUSH_RD;
          end else if (held == '0) begin
            state_next = out_valid ? swcs_pkg::ST_IDLE : swcs_pkg::ST_OUT;
            in_ready = !out_valid;
          end else begin
            state_next = swcs_pkg::ST_Q_RD;
          end
          if (in_item.opcode == swcs_pkg::OP_QUERY && held == '0) begin
            // empty window answers at once
          end
        end
      end
      swcs_pkg::ST_PUSH_RD: begin
        rd_en = 1'b1;
        rd_addr = wr_ptr;
        state_next = swcs_pkg::ST_PUSH_SUB;
      end
      swcs_pkg::ST_PUSH_SUB: begin
        if (phase_wait && ch_idx == 4'(NC - 1)) state_next = swcs_pkg::ST_PUSH_ADD;
      end
      swcs_pkg::ST_PUSH_ADD: begin
        if (phase_wait && ch_idx == 4'(NC - 1)) begin
          wr_en = 1'b1;
          state_next = swcs_pkg::ST_IDLE;
        end
      end
      swcs_pkg::ST_Q_RD: begin
        rd_en = 1'b1;
        rd_addr = '0;
        state_next = swcs_pkg::ST_Q_SCAN;
      end
      swcs_pkg::ST_Q_SCAN: begin
        rd_en = (scan_k != held);
        rd_addr = AW'(scan_k);
        if (scan_k == held) begin
          state_next = swcs_pkg::ST_Q_DIV_IMB;
          req.start = 1'b1;
          req.operand = mag(imb_sum);
          req.divisor = W'(held);
        end
      end
      swcs_pkg::ST_Q_DIV_IMB: begin
        if (rsp.done) begin
          state_next = swcs_pkg::ST_Q_DIV_MEAN;
          req.start = 1'b1;
          req.operand = (col < 4'(NC)) ? mag(ch_sum[col]) : '0;
          req.divisor = W'(held);
        end
      end
      swcs_pkg::ST_Q_DIV_MEAN: begin
        if (rsp.done) begin
          state_next = swcs_pkg::ST_Q_DIV_SQ;
          req.start = 1'b1;
          req.operand = (col < 4'(NC)) ? sq_sum[col] : '0;
          req.divisor = W'(held);
        end
      end
      swcs_pkg::ST_Q_DIV_SQ: begin
        if (rsp.done) begin
          state_next = swcs_pkg::ST_Q_SQRT;
          req.start = 1'b1;
          req.is_sqrt = 1'b1;
          req.operand = rsp.result;
        end
      end
      swcs_pkg::ST_Q_SQRT: begin
        if (rsp.done) state_next = swcs_pkg::ST_OUT;
      end
      swcs_pkg::ST_OUT: begin
        if (!out_valid) state_next = swcs_pkg::ST_IDLE;
      end
      default: state_next = swcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= swcs_pkg::ST_IDLE;
    else state <= state_next;
  end

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      held <= '0;
      imb_sum <= '0;
      out_valid <= 1'b0;
      phase_wait <= 1'b0;
      ch_idx <= '0;
      for (int i = 0; i < NC; i++) begin
        ch_sum[i] <= '0;
        sq_sum[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        swcs_pkg::ST_IDLE: begin
          if (in_fire) begin
            col <= in_item.query_column;
            new_row <= {in_item.sample_ch0, in_item.sample_ch1, in_item.sample_ch2,
                        in_item.sample_ch3, in_item.sample_ch4, in_item.sample_ch5,
                        in_item.sample_ch6, in_item.sample_ch7, in_item.sample_ch8,
                        in_item.sample_ch9};
            ch_idx <= '0;
            phase_wait <= 1'b0;
            mean_q <= '0;
            imb_q <= '0;
            rms_q <= '0;
            mn <= '0;
            peak <= '0;
          end
        end
        swcs_pkg::ST_PUSH_SUB, swcs_pkg::ST_PUSH_ADD: begin
          // product for ch_idx lands in the next cycle; alternate issue/apply
          if (!phase_wait) begin
            phase_wait <= 1'b1;
          end else begin
            if (state == swcs_pkg::ST_PUSH_SUB) begin
              if (held == CW'(WINDOW_DEPTH)) begin
                ch_sum[ch_idx] <= ch_sum[ch_idx] - W'(row_ch(rd_data, ch_idx));
                sq_sum[ch_idx] <= sq_sum[ch_idx] - W'(sq_prod);
                if (ch_idx == '0) imb_sum <= imb_sum - abs_imb(rd_data);
              end
            end else begin
              ch_sum[ch_idx] <= ch_sum[ch_idx] + W'(row_ch(new_row, ch_idx));
              sq_sum[ch_idx] <= sq_sum[ch_idx] + W'(sq_prod);
              if (ch_idx == '0) imb_sum <= imb_sum + abs_imb(new_row);
              if (ch_idx == 4'(NC - 1)) begin
                wr_ptr <= (32'(wr_ptr) == WINDOW_DEPTH - 1) ? '0 : wr_ptr + AW'(1);
                if (held != CW'(WINDOW_DEPTH)) held <= held + CW'(1);
              end
            end
            phase_wait <= 1'b0;
            ch_idx <= (ch_idx == 4'(NC - 1)) ? '0 : ch_idx + 4'd1;
          end
        end
        swcs_pkg::ST_Q_RD: begin
          scan_k <= CW'(1);
          first <= 1'b1;
        end
        swcs_pkg::ST_Q_SCAN: begin
          first <= 1'b0;
          if (scan_k != held) scan_k <= scan_k + CW'(1);
          if (col < 4'(NC)) begin
            if (first || cur_v < mn) mn <= cur_v;
            if (first || cur_a > peak) peak <= cur_a;
          end
          imb_neg <= imb_sum[W-1];
        end
        swcs_pkg::ST_Q_DIV_IMB: begin
          if (rsp.done) begin
            imb_q <= imb_neg ? W'(-rsp.result) : rsp.result;
            mean_neg <= (col < 4'(NC)) && ch_sum[col][W-1];
          end
        end
        swcs_pkg::ST_Q_DIV_MEAN: begin
          if (rsp.done) mean_q <= mean_neg ? -$signed(rsp.result) : $signed(rsp.result);
        end
        swcs_pkg::ST_Q_SQRT: begin
          if (rsp.done) rms_q <= rsp.result;
        end
        swcs_pkg::ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_item.window_mean <= mean_q[SW-1:0];
            out_item.window_rms <= (rms_q > W'(23'h7FFFFF)) ? 23'h7FFFFF : rms_q[22:0];
            out_item.window_minimum <= mn;
            out_item.window_peak_magnitude <= peak;
            out_item.imbalance_mean <= imb_q[25:0];
            out_item.fill_count <= 7'(held);
          end
        end
        default: ;
      endcase
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(WINDOW_DEPTH)) else $error("fill count beyond window");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    32'(wr_ptr) < WINDOW_DEPTH) else $error("write pointer out of range");
  a_out_only_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == swcs_pkg::ST_OUT)
    else $error("result raised outside output state");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == swcs_pkg::ST_Q_SCAN |-> scan_k <= held)
    else $error("scan walked past fill count");
  a_wr_on_push: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == swcs_pkg::ST_PUSH_ADD) else $error("stray ring write");

endmodule

// ----- sim/sliding_window_channel_stats_core_tb.sv -----
module sliding_window_channel_stats_core_tb;

  localparam int DEPTH = swcs_pkg::WINDOW_DEPTH_DEF;
  localparam int NCH = swcs_pkg::NUM_CH;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  swcs_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  swcs_pkg::out_item_t out_item;

  sliding_window_channel_stats_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  logic signed [23:0] ring_q [DEPTH][NCH];
  int unsigned wr_ptr;
  int unsigned held;
  longint ch_sum [NCH];
  longint ch_sq_sum [NCH];
  longint imb_sum;

  swcs_pkg::in_item_t pending_beats [$];
  swcs_pkg::out_item_t expected_stats [$];
  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int stall_cycles;

  // accepted input beat at the last rising edge
  logic in_ready_seen;

  function automatic longint imb_term(input longint a, input longint b, input longint c,
                                      input longint d);
    longint t;
    t = a + b + c - d;
    return (t < 0) ? -t : t;
  endfunction

  function automatic longint trunc_div(input longint s, input longint n);
    longint m;
    m = (s < 0) ? -s : s;
    m = m / n;
    return (s < 0) ? -m : m;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic apply_beat(input swcs_pkg::in_item_t it);
    logic signed [23:0] v [NCH];
    swcs_pkg::out_item_t r;
    longint mn, pk, x, a, rms;
    v = '{it.sample_ch0, it.sample_ch1, it.sample_ch2, it.sample_ch3, it.sample_ch4,
          it.sample_ch5, it.sample_ch6, it.sample_ch7, it.sample_ch8, it.sample_ch9};
    if (it.opcode == swcs_pkg::OP_PUSH) begin
      if (held >= DEPTH) begin
        for (int i = 0; i < NCH; i++) begin
          ch_sum[i] -= longint'(ring_q[wr_ptr][i]);
          ch_sq_sum[i] -= longint'(ring_q[wr_ptr][i]) * longint'(ring_q[wr_ptr][i]);
        end
        imb_sum -= imb_term(ring_q[wr_ptr][0], ring_q[wr_ptr][1], ring_q[wr_ptr][2],
                            ring_q[wr_ptr][6]);
      end
      for (int i = 0; i < NCH; i++) begin
        ring_q[wr_ptr][i] = v[i];
        ch_sum[i] += longint'(v[i]);
        ch_sq_sum[i] += longint'(v[i]) * longint'(v[i]);
      end
      imb_sum += imb_term(v[0], v[1], v[2], v[6]);
      wr_ptr = (wr_ptr + 1) % DEPTH;
      if (held < DEPTH) held++;
    end else begin
      r = '0;
      if (held != 0) begin
        r.imbalance_mean = 26'(trunc_div(imb_sum, held));
        if (it.query_column < NCH) begin
          r.window_mean = 24'(trunc_div(ch_sum[it.query_column], held));
          rms = longint'(floor_root(longint'(ch_sq_sum[it.query_column]) / held));
          if (rms > 64'h7FFFFF) rms = 64'h7FFFFF;
          r.window_rms = 23'(rms);
          mn = ring_q[0][it.query_column];
          pk = (mn < 0) ? -mn : mn;
          for (int k = 1; k < held; k++) begin
            x = ring_q[k][it.query_column];
            a = (x < 0) ? -x : x;
            if (x < mn) mn = x;
            if (a > pk) pk = a;
          end
          r.window_minimum = 24'(mn);
          r.window_peak_magnitude = 24'(pk);
        end
      end
      r.fill_count = 7'(held);
      expected_stats.push_back(r);
    end
  endtask

  function automatic swcs_pkg::in_item_t rand_push(input int mode);
    swcs_pkg::in_item_t it;
    logic [23:0] s;
    it = '0;
    it.opcode = swcs_pkg::OP_PUSH;
    it.query_column = 4'($urandom);
    for (int i = 0; i < NCH; i++) begin
      case (mode)
        0: s = 24'($urandom);
        1: s = ($urandom_range(0, 1) != 0) ? 24'h800000 : 24'h7FFFFF;
        default: s = 24'($signed($urandom_range(0, 8000)) - 4000);
      endcase
      it[239 - 24 * i -: 24] = s;
    end
    return it;
  endfunction

  function automatic swcs_pkg::in_item_t make_query(input logic [3:0] col);
    swcs_pkg::in_item_t it;
    it = '0;
    for (int i = 0; i < NCH; i++) it[239 - 24 * i -: 24] = 24'($urandom);
    it.opcode = swcs_pkg::OP_QUERY;
    it.query_column = col;
    return it;
  endfunction

  // driver: present beats from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    in_ready_seen <= !rst && in_valid && in_ready;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (in_valid && in_ready) begin
        apply_beat(in_item);
      end
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          $error("result beat with no query pending");
          errors++;
        end else begin
          swcs_pkg::out_item_t e;
          e = expected_stats.pop_front();
          if (out_item.window_mean !== e.window_mean) begin
            $error("window_mean exp %0d got %0d", e.window_mean, out_item.window_mean);
            errors++;
          end
          if (out_item.window_rms !== e.window_rms) begin
            $error("window_rms exp %0d got %0d", e.window_rms, out_item.window_rms);
            errors++;
          end
          if (out_item.window_minimum !== e.window_minimum) begin
            $error("window_minimum exp %0d got %0d", e.window_minimum,
                   out_item.window_minimum);
            errors++;
          end
          if (out_item.window_peak_magnitude !== e.window_peak_magnitude) begin
            $error("window_peak_magnitude exp %0d got %0d", e.window_peak_magnitude,
                   out_item.window_peak_magnitude);
            errors++;
          end
          if (out_item.imbalance_mean !== e.imbalance_mean) begin
            $error("imbalance_mean exp %0d got %0d", e.imbalance_mean,
                   out_item.imbalance_mean);
            errors++;
          end
          if (out_item.fill_count !== e.fill_count) begin
            $error("fill_count exp %0d got %0d", e.fill_count, out_item.fill_count);
            errors++;
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL sliding_window_channel_stats_core");
        $finish;
      end
    end
  end

  task automatic drain_phase();
    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    swcs_pkg::in_item_t it;
    int mode;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_item = '0;
    in_ready_seen = 1'b0;
    errors = 0;
    stall_cycles = 0;
    wr_ptr = 0;
    held = 0;
    imb_sum = 0;
    for (int i = 0; i < NCH; i++) begin
      ch_sum[i] = 0;
      ch_sq_sum[i] = 0;
    end
    send_idle_pct = 7;
    recv_idle_pct = 80;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty window, full-scale negative rms, extremes, unused columns
    pending_beats.push_back(make_query(4'd0));
    pending_beats.push_back(make_query(4'd15));
    it = rand_push(0);
    it.sample_ch0 = 24'h800000; it.sample_ch1 = 24'h800000; it.sample_ch2 = 24'h800000;
    it.sample_ch6 = 24'h7FFFFF; it.sample_ch9 = 24'h7FFFFF; it.sample_ch3 = 24'h800000;
    pending_beats.push_back(it);
    for (int c = 0; c < 16; c += 3) pending_beats.push_back(make_query(c[3:0]));
    pending_beats.push_back(make_query(4'd9));
    pending_beats.push_back(make_query(4'd10));
    for (int i = 0; i < 3; i++) pending_beats.push_back(rand_push(1));
    pending_beats.push_back(make_query(4'd1));
    pending_beats.push_back(make_query(4'd6));
    pending_beats.push_back(make_query(4'd15));

    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < 670; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          mode = $urandom_range(0, 9);
          pending_beats.push_back(rand_push(mode == 0 ? 1 : (mode < 6 ? 0 : 2)));
        end else begin
          pending_beats.push_back(make_query(($urandom_range(0, 9) == 0) ?
                                  4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9))));
        end
      end
      drain_phase();
      if (phase == 0) begin
        send_idle_pct = 80;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    while (expected_stats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sliding_window_channel_stats_core");
    end else begin
      $display("FAIL sliding_window_channel_stats_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/swcs_pkg.sv
rtl/core/swcs_arith.sv
rtl/core/sliding_window_channel_stats_core.sv
sim/sliding_window_channel_stats_core_tb.sv
